>>> sv/sca_pkg.sv
`timescale 1ns / 1ps
// Shared types and constants for the sprite clip animator.
// No dependencies; imported by every module.
package sca_pkg;

  localparam int ELAPSED_W = 20;
  localparam int PERIOD_W  = 32;
  localparam int CFG_W     = 64;
  localparam int CFG_IDX_W = 3;

  localparam logic CMD_TICK   = 1'b0;
  localparam logic CMD_SELECT = 1'b1;

  localparam logic [CFG_IDX_W-1:0] REG_CLIP_COUNT   = 3'd0;
  localparam logic [CFG_IDX_W-1:0] REG_CLIP_LENGTHS = 3'd1;
  localparam logic [CFG_IDX_W-1:0] REG_REPEAT_MASK  = 3'd2;
  localparam logic [CFG_IDX_W-1:0] REG_SHEET_COLS   = 3'd3;
  localparam logic [CFG_IDX_W-1:0] REG_CELL_WIDTH   = 3'd4;
  localparam logic [CFG_IDX_W-1:0] REG_CELL_HEIGHT  = 3'd5;
  localparam logic [CFG_IDX_W-1:0] REG_FRAME_PERIOD = 3'd6;

  localparam logic [31:0] FRAME_PERIOD_RST = 32'd166667;
  localparam logic [7:0]  CELL_SIZE_RST    = 8'd16;

  typedef struct packed {
    logic                 command;
    logic [ELAPSED_W-1:0] elapsed_us;
    logic [2:0]           clip_select;
  } sca_item_t;

  typedef struct packed {
    logic [10:0] frame_number;
    logic [15:0] src_x;
    logic [10:0] src_y;
    logic        clip_done;
    logic        select_rejected;
  } sca_result_t;

  typedef struct packed {
    logic [3:0]          clip_count;
    logic [63:0]         clip_lengths;
    logic [7:0]          clip_repeat_mask;
    logic [7:0]          sheet_columns;
    logic [7:0]          cell_width;
    logic [7:0]          cell_height;
    logic [PERIOD_W-1:0] frame_period_us;
  } sca_cfg_t;

  typedef struct packed {
    logic [2:0] clip;
    logic [7:0] frame;
  } sca_pos_t;

endpackage

>>> sv/sca_chan_if.sv
`timescale 1ns / 1ps
// Valid/ready channel carrying one payload struct per transfer.
// Payload type is a parameter; used with sca_pkg item and result types.
interface sca_chan_if #(
  parameter type payload_t = logic
);
  logic     valid;
  logic     ready;
  payload_t data;

  modport source (output valid, output data, input ready);
  modport sink   (input valid, input data, output ready);
endinterface

>>> sv/sca_in_stage.sv
`timescale 1ns / 1ps
// Input register stage of the sprite clip animator.
// Depends on sca_pkg and sca_chan_if.
module sca_in_stage (
  input  logic               clk,
  input  logic               rst_n,
  sca_chan_if.sink           in_ch,
  input  logic               take,
  output logic               item_valid,
  output sca_pkg::sca_item_t item
);
  import sca_pkg::*;

  logic      valid_r;
  logic      valid_nxt;
  sca_item_t item_r;
  logic      load;

  assign in_ch.ready = !valid_r || take;
  assign load        = in_ch.valid && in_ch.ready;
  assign valid_nxt   = load ? 1'b1 : (take ? 1'b0 : valid_r);

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      valid_r <= 1'b0;
    end else begin
      valid_r <= valid_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (load) begin
      item_r <= in_ch.data;
    end
  end

  assign item_valid = valid_r;
  assign item       = item_r;
endmodule

>>> sv/sca_step.sv
`timescale 1ns / 1ps
// Single-pass next-state and result logic for one tick or select transfer.
// Depends on sca_pkg; purely combinational.
module sca_step #(
  parameter int MAX_CLIPS  = 8,
  parameter int TIME_WIDTH = 32
) (
  input  sca_pkg::sca_cfg_t    cfg,
  input  sca_pkg::sca_item_t   item,
  input  sca_pkg::sca_pos_t    pos,
  input  logic [TIME_WIDTH-1:0] acc,
  input  logic [MAX_CLIPS-1:0] ended,
  output sca_pkg::sca_pos_t    pos_nxt,
  output logic [TIME_WIDTH-1:0] acc_nxt,
  output logic [MAX_CLIPS-1:0] ended_nxt,
  output sca_pkg::sca_result_t result
);
  import sca_pkg::*;

  localparam int SUM_W = ((TIME_WIDTH > ELAPSED_W) ? TIME_WIDTH : ELAPSED_W) + 1;
  localparam int CMP_W = (TIME_WIDTH > PERIOD_W) ? TIME_WIDTH : PERIOD_W;
  localparam logic [SUM_W-1:0] TMAX = {{(SUM_W-TIME_WIDTH){1'b0}}, {TIME_WIDTH{1'b1}}};
  localparam logic [3:0] MAX_COUNT = 4'(MAX_CLIPS);

  logic [7:0]            cols;
  logic [7:0]            len_raw;
  logic [7:0]            len_one;
  logic [7:0]            len;
  logic [7:0]            frame_fix;
  logic [3:0]            count_eff;
  logic                  cur_ok;
  logic                  cur_ended;
  logic                  sel_ok;
  logic [PERIOD_W-1:0]   period;
  logic [SUM_W-1:0]      sum;
  logic [TIME_WIDTH-1:0] acc_sat;
  logic [8:0]            frame_inc;
  logic                  done_nxt;

  always_comb begin
    cols      = (cfg.sheet_columns == 8'd0) ? 8'd1 : cfg.sheet_columns;
    len_raw   = cfg.clip_lengths[{pos.clip, 3'b000} +: 8];
    len_one   = (len_raw == 8'd0) ? 8'd1 : len_raw;
    len       = (len_one > cols) ? cols : len_one;
    frame_fix = (pos.frame >= len) ? len - 8'd1 : pos.frame;
    count_eff = (cfg.clip_count > MAX_COUNT) ? MAX_COUNT : cfg.clip_count;
    cur_ok    = {1'b0, pos.clip} < count_eff;
    sel_ok    = {1'b0, item.clip_select} < count_eff;
    cur_ended = 1'b0;
    for (int i = 0; i < MAX_CLIPS; i++) begin
      if (pos.clip == 3'(i)) begin
        cur_ended = ended[i];
      end
    end
    period    = (cfg.frame_period_us == '0) ? PERIOD_W'(1) : cfg.frame_period_us;
    sum       = SUM_W'(acc) + SUM_W'(item.elapsed_us);
    acc_sat   = (sum > TMAX) ? {TIME_WIDTH{1'b1}} : sum[TIME_WIDTH-1:0];
    frame_inc = {1'b0, frame_fix} + 9'd1;

    pos_nxt.clip  = pos.clip;
    pos_nxt.frame = frame_fix;
    acc_nxt       = acc;
    ended_nxt     = ended;
    result.select_rejected = 1'b0;

    case (item.command)
      CMD_TICK: begin
        if (cur_ok && !cur_ended) begin
          if (CMP_W'(acc_sat) >= CMP_W'(period)) begin
            acc_nxt = '0;
            if (frame_inc >= {1'b0, len}) begin
              if (cfg.clip_repeat_mask[pos.clip]) begin
                pos_nxt.frame = 8'd0;
              end else begin
                pos_nxt.frame = len - 8'd1;
                for (int i = 0; i < MAX_CLIPS; i++) begin
                  if (pos.clip == 3'(i)) begin
                    ended_nxt[i] = 1'b1;
                  end
                end
              end
            end else begin
              pos_nxt.frame = frame_inc[7:0];
            end
          end else begin
            acc_nxt = acc_sat;
          end
        end
      end
      CMD_SELECT: begin
        if (!sel_ok) begin
          result.select_rejected = 1'b1;
        end else if (item.clip_select != pos.clip) begin
          pos_nxt.clip  = item.clip_select;
          pos_nxt.frame = 8'd0;
          acc_nxt       = '0;
          for (int i = 0; i < MAX_CLIPS; i++) begin
            if (item.clip_select == 3'(i)) begin
              ended_nxt[i] = 1'b0;
            end
          end
        end
      end
      default: begin
        acc_nxt = acc;
      end
    endcase

    done_nxt = 1'b0;
    for (int i = 0; i < MAX_CLIPS; i++) begin
      if (pos_nxt.clip == 3'(i)) begin
        done_nxt = ended_nxt[i];
      end
    end

    result.frame_number = 11'(pos_nxt.clip) * 11'(cols) + 11'(pos_nxt.frame);
    result.src_x        = 16'(pos_nxt.frame) * 16'(cfg.cell_width);
    result.src_y        = 11'(pos_nxt.clip) * 11'(cfg.cell_height);
    result.clip_done    = done_nxt;
  end
endmodule

>>> sv/sprite_clip_animator.sv
`timescale 1ns / 1ps
// Sprite-sheet frame sequencer: top level with configuration, state and result register.
// Depends on sca_pkg, sca_chan_if, sca_in_stage and sca_step.
//
// Usage:
//   in_ch carries tick items (elapsed microseconds) and select items (clip index).
//   out_ch returns one result per item: absolute frame, source-rectangle origin,
//   the clip's ended flag and a flag for a rejected select.
//   cfg_we/cfg_index/cfg_wdata write one register per cycle; write only while idle.
// Path: an item passes the input register, then the state update and the result
//   register in one pass.
// Throughput: one item per cycle while out_ch is ready; the state update is a single
//   accumulate, compare and increment feeding the result register.
// Reset: synchronous, active low; clears both channels, the clip position, the
//   accumulator and all ended flags, and loads register defaults.
// Stall: while out_ch is not ready the result holds, the input register fills
//   and then in_ch.ready drops; no item is lost or repeated.
module sprite_clip_animator #(
  parameter int MAX_CLIPS  = 8,
  parameter int TIME_WIDTH = 32
) (
  input  logic                            clk,
  input  logic                            rst_n,
  sca_chan_if.sink                        in_ch,
  sca_chan_if.source                      out_ch,
  input  logic                            cfg_we,
  input  logic [sca_pkg::CFG_IDX_W-1:0]   cfg_index,
  input  logic [sca_pkg::CFG_W-1:0]       cfg_wdata
);
  import sca_pkg::*;

  sca_cfg_t              cfg_r;
  sca_pos_t              pos_r;
  sca_pos_t              pos_nxt;
  logic [TIME_WIDTH-1:0] acc_r;
  logic [TIME_WIDTH-1:0] acc_nxt;
  logic [MAX_CLIPS-1:0]  ended_r;
  logic [MAX_CLIPS-1:0]  ended_nxt;
  logic                  out_valid_r;
  sca_result_t           out_data_r;
  sca_result_t           result;
  logic                  item_valid;
  sca_item_t             item;
  logic                  take;

  assign take = item_valid && (!out_valid_r || out_ch.ready);

  sca_in_stage u_in_stage (
    .clk        (clk),
    .rst_n      (rst_n),
    .in_ch      (in_ch),
    .take       (take),
    .item_valid (item_valid),
    .item       (item)
  );

  sca_step #(
    .MAX_CLIPS  (MAX_CLIPS),
    .TIME_WIDTH (TIME_WIDTH)
  ) u_step (
    .cfg       (cfg_r),
    .item      (item),
    .pos       (pos_r),
    .acc       (acc_r),
    .ended     (ended_r),
    .pos_nxt   (pos_nxt),
    .acc_nxt   (acc_nxt),
    .ended_nxt (ended_nxt),
    .result    (result)
  );

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cfg_r.clip_count       <= 4'd0;
      cfg_r.clip_lengths     <= 64'd0;
      cfg_r.clip_repeat_mask <= 8'd0;
      cfg_r.sheet_columns    <= 8'd1;
      cfg_r.cell_width       <= CELL_SIZE_RST;
      cfg_r.cell_height      <= CELL_SIZE_RST;
      cfg_r.frame_period_us  <= FRAME_PERIOD_RST;
    end else if (cfg_we) begin
      case (cfg_index)
        REG_CLIP_COUNT:   cfg_r.clip_count       <= cfg_wdata[3:0];
        REG_CLIP_LENGTHS: cfg_r.clip_lengths     <= cfg_wdata;
        REG_REPEAT_MASK:  cfg_r.clip_repeat_mask <= cfg_wdata[7:0];
        REG_SHEET_COLS:   cfg_r.sheet_columns    <= cfg_wdata[7:0];
        REG_CELL_WIDTH:   cfg_r.cell_width       <= cfg_wdata[7:0];
        REG_CELL_HEIGHT:  cfg_r.cell_height      <= cfg_wdata[7:0];
        REG_FRAME_PERIOD: cfg_r.frame_period_us  <= cfg_wdata[PERIOD_W-1:0];
        default:          cfg_r                  <= cfg_r;
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      pos_r       <= '0;
      acc_r       <= '0;
      ended_r     <= '0;
      out_valid_r <= 1'b0;
    end else if (take) begin
      pos_r       <= pos_nxt;
      acc_r       <= acc_nxt;
      ended_r     <= ended_nxt;
      out_valid_r <= 1'b1;
    end else if (out_ch.ready) begin
      out_valid_r <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (take) begin
      out_data_r <= result;
    end
  end

  assign out_ch.valid = out_valid_r;
  assign out_ch.data  = out_data_r;

  a_reset_clears_ended: assert property (@(posedge clk)
    !rst_n |=> ended_r == '0)
    else $error("ended flags not cleared by reset");

  a_tick_keeps_clip: assert property (@(posedge clk) disable iff (!rst_n)
    take && item.command == CMD_TICK |=> pos_r.clip == $past(pos_r.clip))
    else $error("tick changed the current clip");

  a_reject_keeps_state: assert property (@(posedge clk) disable iff (!rst_n)
    take && result.select_rejected |=>
      pos_r.clip == $past(pos_r.clip) && acc_r == $past(acc_r) && ended_r == $past(ended_r))
    else $error("rejected select changed state");

  a_done_has_flag: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid_r && out_data_r.clip_done |-> ended_r != '0)
    else $error("clip_done reported with no ended flag set");
endmodule
